FILE: src/llcarq_pkg.sv
// shared types and constants for the llc arq receive reassembly core
// no dependencies, compiled first
`timescale 1ns / 1ps

package llcarq_pkg;

  localparam int PEER_ENTRIES = 8;
  localparam int SLOT_W = $clog2(PEER_ENTRIES);

  localparam logic [7:0] HDR_BYTES        = 8'd3;
  localparam logic [7:0] FRAME_MAX_BYTES  = 8'd32;
  localparam logic [7:0] PAYLOAD_MAX      = FRAME_MAX_BYTES - HDR_BYTES;
  localparam logic [7:0] PACKET_MAX_BYTES = 8'd128;
  localparam logic [7:0] SEQ_IDLE         = 8'hff;
  localparam logic [1:0] NO_BIT           = 2'd3;
  localparam logic [7:0] BCAST_RESET      = 8'hff;

  localparam logic [3:0] ST_BAD_LENGTH   = 4'd0;
  localparam logic [3:0] ST_ACK_SEEN     = 4'd1;
  localparam logic [3:0] ST_UNACK_DELIV  = 4'd2;
  localparam logic [3:0] ST_UNACK_DROP   = 4'd3;
  localparam logic [3:0] ST_NEW_OOO      = 4'd4;
  localparam logic [3:0] ST_SINGLE_DELIV = 4'd5;
  localparam logic [3:0] ST_STARTED      = 4'd6;
  localparam logic [3:0] ST_APPENDED     = 4'd7;
  localparam logic [3:0] ST_COMPLETED    = 4'd8;
  localparam logic [3:0] ST_DUPLICATE    = 4'd9;
  localparam logic [3:0] ST_GAP_RESET    = 4'd10;
  localparam logic [3:0] ST_OVERFLOW     = 4'd11;
  localparam logic [3:0] ST_EMPTY_ACKED  = 4'd12;

  typedef struct packed {
    logic [7:0] frame_length;
    logic [7:0] source_address;
    logic       is_ack_frame;
    logic       ack_required;
    logic       alternating_bit;
    logic       is_final;
    logic [7:0] sequence_req;
    logic [7:0] payload_length;
  } frame_t;

  typedef struct packed {
    logic [3:0] status;
    logic       send_ack;
    logic [7:0] ack_sequence;
    logic       ack_alternating;
    logic       deliver;
    logic [7:0] deliver_length;
    logic       acknowledged_delivery;
    logic [2:0] peer_slot;
    logic       store_payload;
    logic [7:0] write_offset;
  } result_t;

  typedef struct packed {
    logic load;
    logic lookup;
    logic exec;
    logic push;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/llcarq_ctrl.sv
// controller state machine: sequences accept, peer lookup, update and hand-over
// depends on llcarq_pkg
`timescale 1ns / 1ps

module llcarq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   frame_valid,
  output logic                   frame_stall,
  output llcarq_pkg::dp_cmd_t    cmd,
  input  llcarq_pkg::dp_status_t sts
);
  import llcarq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_PUSH
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    frame_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        frame_stall = rst;
        cmd.load = frame_valid && !rst;
      end
      S_LOOKUP: cmd.lookup = 1'b1;
      S_EXEC:   cmd.exec = 1'b1;
      S_PUSH:   cmd.push = sts.out_free;
      default:  cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:   if (frame_valid) state <= S_LOOKUP;
        S_LOOKUP: state <= S_EXEC;
        S_EXEC:   state <= S_PUSH;
        S_PUSH:   if (sts.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/llcarq_dp.sv
// datapath: frame register, peer table, victim pointer, decision logic, output register
// depends on llcarq_pkg
`timescale 1ns / 1ps

module llcarq_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_data,
  input  llcarq_pkg::frame_t     frame,
  input  llcarq_pkg::dp_cmd_t    cmd,
  output llcarq_pkg::dp_status_t sts,
  output logic                   result_valid,
  input  logic                   result_stall,
  output llcarq_pkg::result_t    result
);
  import llcarq_pkg::*;

  logic [7:0]        bcast;
  frame_t            fr;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] victim;
  result_t           hold;

  logic [7:0] peer_address  [PEER_ENTRIES];
  logic [1:0] peer_last_bit [PEER_ENTRIES];
  logic [7:0] peer_sequence [PEER_ENTRIES];
  logic [7:0] peer_fill     [PEER_ENTRIES];
  logic       peer_active   [PEER_ENTRIES];

  // frame classification
  logic len_bad, unacked, uses_table;

  assign len_bad = (fr.frame_length < HDR_BYTES) || (fr.frame_length > FRAME_MAX_BYTES) ||
                   (fr.payload_length > PAYLOAD_MAX);
  assign unacked = (fr.source_address == bcast) || !fr.ack_required;
  assign uses_table = !len_bad && !fr.is_ack_frame && !unacked;

  // peer search, highest index wins
  logic              hit, have_free;
  logic [SLOT_W-1:0] hit_idx, free_idx, lookup_slot;
  logic              claim;

  always_comb begin
    hit = 1'b0;
    have_free = 1'b0;
    hit_idx = '0;
    free_idx = '0;
    for (int i = 0; i < PEER_ENTRIES; i++) begin
      if (peer_address[i] == fr.source_address) begin
        hit = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (peer_address[i] == bcast) begin
        have_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
    claim = !hit;
    if (hit) lookup_slot = hit_idx;
    else if (have_free) lookup_slot = free_idx;
    else lookup_slot = victim;
  end

  // decision on the selected entry
  logic [1:0] e_last, n_last;
  logic [7:0] e_seq, n_seq, e_fill, n_fill, fill_now;
  logic       e_active, n_active;
  logic [8:0] fill_sum;
  result_t    r;

  assign e_last   = peer_last_bit[slot];
  assign e_seq    = peer_sequence[slot];
  assign e_fill   = peer_fill[slot];
  assign e_active = peer_active[slot];
  assign fill_sum = {1'b0, e_fill} + {1'b0, fr.payload_length};

  always_comb begin
    r = '0;
    n_last = e_last;
    n_seq = e_seq;
    n_fill = e_fill;
    n_active = e_active;
    fill_now = e_fill;
    if (len_bad) begin
      r.status = ST_BAD_LENGTH;
    end else if (fr.is_ack_frame) begin
      r.status = ST_ACK_SEEN;
      r.ack_sequence = fr.sequence_req;
      r.ack_alternating = fr.alternating_bit;
    end else if (unacked) begin
      if ((fr.sequence_req == 8'd0) && fr.is_final) begin
        r.status = ST_UNACK_DELIV;
        r.deliver = 1'b1;
        r.deliver_length = fr.payload_length;
      end else begin
        r.status = ST_UNACK_DROP;
      end
    end else begin
      r.peer_slot = 3'(slot);
      if ({1'b0, fr.alternating_bit} != e_last) begin
        if (fr.sequence_req != 8'd0) begin
          r.status = ST_NEW_OOO;
        end else if (fr.is_final) begin
          n_seq = SEQ_IDLE;
          n_last = {1'b0, fr.alternating_bit};
          r.send_ack = 1'b1;
          if (fr.payload_length != 8'd0) begin
            r.status = ST_SINGLE_DELIV;
            r.deliver = 1'b1;
            r.deliver_length = fr.payload_length;
            r.acknowledged_delivery = 1'b1;
          end else begin
            r.status = ST_EMPTY_ACKED;
          end
        end else if (fr.payload_length > PACKET_MAX_BYTES) begin
          r.status = ST_OVERFLOW;
        end else begin
          r.status = ST_STARTED;
          n_active = 1'b1;
          n_fill = fr.payload_length;
          n_seq = 8'd0;
          n_last = {1'b0, fr.alternating_bit};
          r.store_payload = 1'b1;
          r.send_ack = 1'b1;
        end
      end else if ((fr.sequence_req != 8'd0) && (fr.sequence_req != e_seq)) begin
        if ({1'b0, fr.sequence_req} != ({1'b0, e_seq} + 9'd1)) begin
          r.status = ST_GAP_RESET;
          n_last = NO_BIT;
        end else if (fill_sum > {1'b0, PACKET_MAX_BYTES}) begin
          r.status = ST_OVERFLOW;
        end else begin
          r.status = ST_APPENDED;
          if (e_active) begin
            r.store_payload = 1'b1;
            r.write_offset = e_fill;
            fill_now = fill_sum[7:0];
            n_fill = fill_sum[7:0];
          end
          if (fr.is_final) begin
            if (fill_now != 8'd0) begin
              r.status = ST_COMPLETED;
              r.deliver = 1'b1;
              r.deliver_length = fill_now;
              r.acknowledged_delivery = 1'b1;
              n_active = 1'b0;
              n_fill = 8'd0;
            end else begin
              r.status = ST_EMPTY_ACKED;
            end
          end
          n_seq = fr.sequence_req;
          r.send_ack = 1'b1;
        end
      end else begin
        r.status = ST_DUPLICATE;
        r.send_ack = 1'b1;
      end
      if (r.send_ack) begin
        r.ack_sequence = fr.sequence_req;
        r.ack_alternating = fr.alternating_bit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bcast <= BCAST_RESET;
    end else if (cfg_we) begin
      bcast <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) fr <= frame;
    if (cmd.lookup) slot <= lookup_slot;
    if (cmd.exec) hold <= r;
  end

  // peer table
  always_ff @(posedge clk) begin
    if (rst) begin
      victim <= SLOT_W'(PEER_ENTRIES - 1);
      for (int i = 0; i < PEER_ENTRIES; i++) begin
        peer_address[i]  <= BCAST_RESET;
        peer_last_bit[i] <= NO_BIT;
        peer_sequence[i] <= SEQ_IDLE;
        peer_fill[i]     <= 8'd0;
        peer_active[i]   <= 1'b0;
      end
    end else if (cmd.lookup && uses_table && claim) begin
      peer_address[lookup_slot]  <= fr.source_address;
      peer_last_bit[lookup_slot] <= NO_BIT;
      peer_sequence[lookup_slot] <= SEQ_IDLE;
      peer_fill[lookup_slot]     <= 8'd0;
      peer_active[lookup_slot]   <= 1'b0;
      if (!have_free) begin
        victim <= (victim == '0) ? SLOT_W'(PEER_ENTRIES - 1) : victim - 1'b1;
      end
    end else if (cmd.exec && uses_table) begin
      peer_last_bit[slot] <= n_last;
      peer_sequence[slot] <= n_seq;
      peer_fill[slot]     <= n_fill;
      peer_active[slot]   <= n_active;
    end
  end

  // output register
  assign sts.out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) result <= hold;
  end

endmodule

FILE: src/llc_arq_receive_reassembly_core.sv
// top level of the llc arq receive reassembly core
// depends on llcarq_pkg, llcarq_ctrl and llcarq_dp
`timescale 1ns / 1ps

// Receive side of an alternating-bit stop-and-wait link layer with an
// eight-entry peer table. One frame header word is taken at a time and gives
// exactly one result word. A frame passes through accept, peer lookup and
// entry claim, entry update with the result decision, and hand-over to the
// output register; the next frame is accepted in the cycle after hand-over.
// The lookup and update both work on the single register-based peer table.
// A result waiting in the output register does not hold up the next frame
// until its own hand-over, which waits for the output stall to drop. The
// broadcast address register is written through the cfg channel, which is
// ready whenever reset is low; write it only while no frame is in flight.

module llc_arq_receive_reassembly_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  logic                frame_valid,
  output logic                frame_stall,
  input  llcarq_pkg::frame_t  frame,
  output logic                result_valid,
  input  logic                result_stall,
  output llcarq_pkg::result_t result
);
  import llcarq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  assign cfg_ready = !rst;

  llcarq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .cmd         (cmd),
    .sts         (sts)
  );

  llcarq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .frame        (frame),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: src/llcarq_chk.sv
// port-level checker for the llc arq receive reassembly core, with its bind
// depends on llcarq_pkg and llc_arq_receive_reassembly_core
`timescale 1ns / 1ps

module llcarq_chk (
  input logic                clk,
  input logic                rst,
  input logic                frame_valid,
  input logic                frame_stall,
  input logic                result_valid,
  input logic                result_stall,
  input llcarq_pkg::result_t result
);
  import llcarq_pkg::*;

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed under stall");

  // one frame in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall |=> frame_stall)
    else $error("frame accepted while busy");

  // delivery only for delivering statuses
  a_deliver_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.deliver |->
      (result.status == ST_UNACK_DELIV || result.status == ST_SINGLE_DELIV ||
       result.status == ST_COMPLETED))
    else $error("delivery with wrong status");

  // no table entry for frames outside the peer table
  a_slot_unused: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status == ST_BAD_LENGTH || result.status == ST_ACK_SEEN ||
                     result.status == ST_UNACK_DELIV || result.status == ST_UNACK_DROP)
      |-> result.peer_slot == 3'd0 && !result.send_ack && !result.store_payload)
    else $error("table fields set outside peer path");

  // output empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind llc_arq_receive_reassembly_core llcarq_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .frame_valid  (frame_valid),
  .frame_stall  (frame_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

FILE: sim/tb_top.sv
// self-checking bench for llc_arq_receive_reassembly_core: directed and random frames with
// idling on both channels, results checked against a peer table model kept in this file
// depends on llcarq_pkg and the core sources
`timescale 1ns / 1ps

module tb_top;
  import llcarq_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  logic    frame_valid = 1'b0;
  logic    frame_stall;
  frame_t  frame = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  llc_arq_receive_reassembly_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #2 clk = ~clk;

  // peer table copy
  logic [7:0] bcast_addr;
  logic [7:0] addr_tab [PEER_ENTRIES];
  logic [1:0] last_bit_tab [PEER_ENTRIES];
  logic [7:0] seq_tab [PEER_ENTRIES];
  logic [7:0] fill_tab [PEER_ENTRIES];
  logic       active_tab [PEER_ENTRIES];
  logic [2:0] victim_ptr;

  frame_t  frames_to_send [$];
  result_t outcomes_due [$];
  logic    frame_taken = 1'b0;
  int      fail_count = 0;

  // sender stream state per address
  logic       gen_bit [256];
  logic [7:0] gen_seq [256];
  int         gen_left [256];
  frame_t     last_stream;
  logic [7:0] pool [16];
  int         pool_size = 6;

  int gap_left = 0;
  int burst_left = 0;
  int stall_left = 0;
  int calm_left = 0;

  function automatic void clear_entry(input int i);
    addr_tab[i] = bcast_addr;
    last_bit_tab[i] = NO_BIT;
    seq_tab[i] = SEQ_IDLE;
    fill_tab[i] = 8'd0;
    active_tab[i] = 1'b0;
  endfunction

  task automatic reset_table();
    bcast_addr = BCAST_RESET;
    for (int i = 0; i < PEER_ENTRIES; i++) clear_entry(i);
    victim_ptr = 3'(PEER_ENTRIES - 1);
  endtask

  function automatic logic [2:0] claim_slot(input logic [7:0] src);
    logic have_free;
    logic found;
    logic [2:0] free_slot;
    logic [2:0] slot;
    have_free = 1'b0;
    found = 1'b0;
    free_slot = 3'd0;
    slot = 3'd0;
    for (int i = PEER_ENTRIES - 1; i >= 0; i--) begin
      if (!found) begin
        if (!have_free && addr_tab[i] == bcast_addr) begin
          have_free = 1'b1;
          free_slot = 3'(i);
        end
        if (addr_tab[i] == src) begin
          found = 1'b1;
          slot = 3'(i);
        end
      end
    end
    if (!found) begin
      if (have_free) begin
        slot = free_slot;
      end else begin
        slot = victim_ptr;
        victim_ptr = (slot == 3'd0) ? 3'(PEER_ENTRIES - 1) : slot - 3'd1;
      end
      clear_entry(int'(slot));
      addr_tab[slot] = src;
    end
    return slot;
  endfunction

  function automatic result_t receive_frame(input frame_t f);
    result_t r;
    logic [2:0] slot;
    logic [1:0] bitw;
    int fill;
    r = '0;
    if (f.frame_length < HDR_BYTES || f.frame_length > FRAME_MAX_BYTES ||
        f.payload_length > PAYLOAD_MAX) begin
      r.status = ST_BAD_LENGTH;
    end else if (f.is_ack_frame) begin
      r.status = ST_ACK_SEEN;
      r.ack_sequence = f.sequence_req;
      r.ack_alternating = f.alternating_bit;
    end else if (f.source_address == bcast_addr || !f.ack_required) begin
      if (f.sequence_req == 8'd0 && f.is_final) begin
        r.status = ST_UNACK_DELIV;
        r.deliver = 1'b1;
        r.deliver_length = f.payload_length;
      end else begin
        r.status = ST_UNACK_DROP;
      end
    end else begin
      slot = claim_slot(f.source_address);
      r.peer_slot = slot;
      bitw = {1'b0, f.alternating_bit};
      if (bitw != last_bit_tab[slot]) begin
        if (f.sequence_req != 8'd0) begin
          r.status = ST_NEW_OOO;
        end else if (f.is_final) begin
          seq_tab[slot] = SEQ_IDLE;
          last_bit_tab[slot] = bitw;
          r.send_ack = 1'b1;
          if (f.payload_length != 8'd0) begin
            r.status = ST_SINGLE_DELIV;
            r.deliver = 1'b1;
            r.deliver_length = f.payload_length;
            r.acknowledged_delivery = 1'b1;
          end else begin
            r.status = ST_EMPTY_ACKED;
          end
        end else if (f.payload_length > PACKET_MAX_BYTES) begin
          r.status = ST_OVERFLOW;
        end else begin
          r.status = ST_STARTED;
          active_tab[slot] = 1'b1;
          fill_tab[slot] = f.payload_length;
          seq_tab[slot] = 8'd0;
          last_bit_tab[slot] = bitw;
          r.store_payload = 1'b1;
          r.send_ack = 1'b1;
        end
      end else if (f.sequence_req != 8'd0 && f.sequence_req != seq_tab[slot]) begin
        fill = int'(fill_tab[slot]);
        if (int'(f.sequence_req) != int'(seq_tab[slot]) + 1) begin
          r.status = ST_GAP_RESET;
          last_bit_tab[slot] = NO_BIT;
        end else if (fill + int'(f.payload_length) > int'(PACKET_MAX_BYTES)) begin
          r.status = ST_OVERFLOW;
        end else begin
          r.status = ST_APPENDED;
          if (active_tab[slot]) begin
            r.store_payload = 1'b1;
            r.write_offset = 8'(fill);
            fill = fill + int'(f.payload_length);
            fill_tab[slot] = 8'(fill);
          end
          if (f.is_final) begin
            if (fill != 0) begin
              r.status = ST_COMPLETED;
              r.deliver = 1'b1;
              r.deliver_length = 8'(fill);
              r.acknowledged_delivery = 1'b1;
              active_tab[slot] = 1'b0;
              fill_tab[slot] = 8'd0;
            end else begin
              r.status = ST_EMPTY_ACKED;
            end
          end
          seq_tab[slot] = f.sequence_req;
          r.send_ack = 1'b1;
        end
      end else begin
        r.status = ST_DUPLICATE;
        r.send_ack = 1'b1;
      end
      if (r.send_ack) begin
        r.ack_sequence = f.sequence_req;
        r.ack_alternating = f.alternating_bit;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: config copy, result check, frame acceptance
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      frame_taken <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) bcast_addr = cfg_data;
      if (result_valid && !result_stall) begin
        if (outcomes_due.size() == 0) begin
          $error("result word with none outstanding, status %0d", result.status);
          fail_count++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("status", int'(want.status), int'(result.status));
          check_field("send_ack", int'(want.send_ack), int'(result.send_ack));
          check_field("ack_sequence", int'(want.ack_sequence), int'(result.ack_sequence));
          check_field("ack_alternating", int'(want.ack_alternating),
                      int'(result.ack_alternating));
          check_field("deliver", int'(want.deliver), int'(result.deliver));
          check_field("deliver_length", int'(want.deliver_length),
                      int'(result.deliver_length));
          check_field("acknowledged_delivery", int'(want.acknowledged_delivery),
                      int'(result.acknowledged_delivery));
          check_field("peer_slot", int'(want.peer_slot), int'(result.peer_slot));
          check_field("store_payload", int'(want.store_payload),
                      int'(result.store_payload));
          check_field("write_offset", int'(want.write_offset), int'(result.write_offset));
        end
      end
      if (frame_valid && !frame_stall) outcomes_due.push_back(receive_frame(frame));
      frame_taken <= frame_valid && !frame_stall;
    end
  end

  function automatic int pick_gap();
    int k;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    k = $urandom_range(0, 99);
    if (k < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // frame driver
  always @(negedge clk) begin : frame_drive
    logic nv;
    frame_t nf;
    nv = frame_valid;
    nf = frame;
    if (!rst && !(frame_valid && !frame_taken)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (frames_to_send.size() > 0) begin
        nf = frames_to_send.pop_front();
        nv = 1'b1;
        gap_left = pick_gap();
      end
    end
    frame_valid <= nv;
    frame <= nf;
  end

  // result stall
  always @(negedge clk) begin : stall_drive
    logic ns;
    int k;
    ns = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if (calm_left > 0) begin
      calm_left--;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 1) calm_left = $urandom_range(50, 200);
      else if (k < 60) ns = 1'b0;
      else if (k < 95) begin
        ns = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else begin
        ns = 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
    result_stall <= ns;
  end

  task automatic push_frame(input int flen, input logic [7:0] src, input logic ack,
                            input logic req, input logic abit, input logic fin,
                            input int seq, input int plen);
    frame_t f;
    f.frame_length = 8'(flen);
    f.source_address = src;
    f.is_ack_frame = ack;
    f.ack_required = req;
    f.alternating_bit = abit;
    f.is_final = fin;
    f.sequence_req = 8'(seq);
    f.payload_length = 8'(plen);
    frames_to_send.push_back(f);
  endtask

  task automatic push_stream_frame(input logic [7:0] addr);
    int plen;
    int k;
    if (gen_left[addr] <= 0) begin
      gen_bit[addr] = ~gen_bit[addr];
      gen_seq[addr] = 8'd0;
      gen_left[addr] = ($urandom_range(0, 99) < 30) ? 1 : $urandom_range(2, 7);
    end
    k = $urandom_range(0, 9);
    if (k == 0) plen = 0;
    else if (k < 4) plen = int'(PAYLOAD_MAX);
    else plen = $urandom_range(0, int'(PAYLOAD_MAX));
    push_frame(plen + 3, addr, 1'b0, 1'b1, gen_bit[addr], gen_left[addr] == 1,
               int'(gen_seq[addr]), plen);
    last_stream = frames_to_send[$];
    gen_seq[addr] = gen_seq[addr] + 8'd1;
    gen_left[addr]--;
  endtask

  task automatic push_random_frame();
    int k;
    logic [7:0] addr;
    addr = pool[$urandom_range(0, pool_size - 1)];
    k = $urandom_range(0, 99);
    if (k < 74) begin
      push_stream_frame(addr);
    end else if (k < 78) begin
      frames_to_send.push_back(last_stream);
    end else if (k < 81) begin
      gen_seq[addr] = gen_seq[addr] + 8'($urandom_range(1, 3));
      push_stream_frame(addr);
    end else if (k < 84) begin
      push_frame($urandom_range(3, 32), 8'($urandom), 1'b1, 1'($urandom), 1'($urandom),
                 1'($urandom), $urandom_range(0, 255), $urandom_range(0, 29));
    end else if (k < 87) begin
      push_frame($urandom_range(3, 32), addr, 1'b0, 1'b0, 1'($urandom), 1'($urandom),
                 ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, 255),
                 $urandom_range(0, 29));
    end else if (k < 89) begin
      push_frame($urandom_range(3, 32), bcast_addr, 1'b0, 1'b1, 1'($urandom),
                 1'($urandom), $urandom_range(0, 1), $urandom_range(0, 29));
    end else if (k < 93) begin
      if ($urandom_range(0, 1) == 1)
        push_frame(($urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : $urandom_range(33, 255),
                   addr, 1'($urandom), 1'b1, 1'($urandom), 1'($urandom),
                   $urandom_range(0, 255), $urandom_range(0, 29));
      else
        push_frame($urandom_range(3, 32), addr, 1'($urandom), 1'b1, 1'($urandom),
                   1'($urandom), $urandom_range(0, 255), $urandom_range(30, 255));
    end else if (k < 96) begin
      gen_left[addr] = 0;
      push_stream_frame(addr);
    end else begin
      push_frame($urandom_range(0, 255), 8'($urandom), 1'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom), $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (!(frames_to_send.size() == 0 && !frame_valid && outcomes_due.size() == 0));
    repeat (12) @(posedge clk);
  endtask

  task automatic write_broadcast(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_directed();
    push_frame(2, 8'h10, 1'b0, 1'b1, 1'b0, 1'b1, 0, 0);
    push_frame(33, 8'h10, 1'b0, 1'b1, 1'b0, 1'b1, 0, 0);
    push_frame(10, 8'h10, 1'b0, 1'b1, 1'b0, 1'b1, 0, 30);
    push_frame(0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 0, 0);
    push_frame(255, 8'hfe, 1'b1, 1'b1, 1'b1, 1'b1, 255, 255);
    push_frame(3, 8'h20, 1'b1, 1'b0, 1'b1, 1'b0, 'hab, 0);
    push_frame(32, 8'hff, 1'b1, 1'b1, 1'b0, 1'b1, 255, 29);
    push_frame(8, 8'h21, 1'b0, 1'b0, 1'b1, 1'b1, 0, 5);
    push_frame(8, 8'h21, 1'b0, 1'b0, 1'b0, 1'b1, 1, 5);
    push_frame(8, 8'hff, 1'b0, 1'b1, 1'b0, 1'b1, 0, 5);
    // single frames, repeat and empty single
    push_frame(10, 8'h10, 1'b0, 1'b1, 1'b1, 1'b1, 0, 7);
    push_frame(10, 8'h10, 1'b0, 1'b1, 1'b1, 1'b1, 0, 7);
    push_frame(3, 8'h10, 1'b0, 1'b1, 1'b0, 1'b1, 0, 0);
    // full packet with duplicate, overflow and completion at the packet limit
    push_frame(32, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 0, 29);
    push_frame(32, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 1, 29);
    push_frame(32, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 1, 29);
    push_frame(32, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 2, 29);
    push_frame(32, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 3, 29);
    push_frame(32, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 4, 29);
    push_frame(15, 8'h11, 1'b0, 1'b1, 1'b0, 1'b1, 4, 12);
    // in sequence with no active buffer, then a gap and an out-of-order start
    push_frame(5, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 5, 2);
    push_frame(5, 8'h11, 1'b0, 1'b1, 1'b0, 1'b0, 7, 2);
    push_frame(5, 8'h12, 1'b0, 1'b1, 1'b1, 1'b0, 3, 2);
    // sequence left idle after a single frame
    push_frame(6, 8'h13, 1'b0, 1'b1, 1'b1, 1'b1, 0, 3);
    push_frame(6, 8'h13, 1'b0, 1'b1, 1'b1, 1'b0, 1, 3);
    // empty packet ending in an empty final
    push_frame(3, 8'h14, 1'b0, 1'b1, 1'b1, 1'b0, 0, 0);
    push_frame(3, 8'h14, 1'b0, 1'b1, 1'b1, 1'b1, 1, 0);
  endtask

  initial begin : sequencer
    logic [7:0] cfg_vals [5];
    int pool_sizes [5];
    cfg_vals = '{8'hff, 8'h00, 8'hff, 8'($urandom), 8'h5a};
    pool_sizes = '{6, 6, 12, 9, 16};
    for (int a = 0; a < 256; a++) begin
      gen_bit[a] = 1'($urandom);
      gen_seq[a] = 8'd0;
      gen_left[a] = 0;
    end
    reset_table();
    last_stream = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_broadcast(cfg_vals[0]);
    load_directed();
    wait_drain();
    for (int ph = 1; ph < 5; ph++) begin
      write_broadcast(cfg_vals[ph]);
      pool_size = pool_sizes[ph];
      for (int p = 0; p < pool_size; p++) begin
        pool[p] = 8'($urandom);
        if (pool[p] == cfg_vals[ph]) pool[p] = pool[p] ^ 8'h01;
      end
      last_stream = '0;
      repeat (382) push_random_frame();
      wait_drain();
    end
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sim.f
src/llcarq_pkg.sv
src/llcarq_ctrl.sv
src/llcarq_dp.sv
src/llc_arq_receive_reassembly_core.sv
src/llcarq_chk.sv
sim/tb_top.sv
